[src/bpa_pkg.sv]
`timescale 1ns / 1ps
// Package for the buddy page allocator: sizes, item types, codes,
// controller states, datapath commands and order helper functions.
package bpa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int NUM_ORDERS = 11;
  localparam int TOP_ORDER  = NUM_ORDERS - 1;

  localparam int IDX_W   = $clog2(MAX_PAGES);
  localparam int SPAN_W  = IDX_W + 1;
  localparam int ORD_W   = $clog2(NUM_ORDERS + 1);
  localparam int CNT_W   = 11;
  localparam int PAGE_W  = 20;
  localparam int STAT_W  = 2;
  localparam int REG_W   = 1;

  localparam int WORD_W  = (MAX_PAGES < 64) ? MAX_PAGES : 64;
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int WORDS   = MAX_PAGES / WORD_W;
  localparam int WSEL_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROWS    = NUM_ORDERS * WORDS;
  localparam int ROW_W   = $clog2(ROWS);
  localparam int BCNT_W  = SPAN_W;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STAT_W-1:0] ST_BAD      = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [REG_W-1:0] REG_REGION_PAGES = 1'b0;
  localparam logic [REG_W-1:0] REG_REGION_START = 1'b1;

  localparam logic [CNT_W-1:0] REGION_RESET = CNT_W'(1024);

  typedef struct packed {
    logic              op;
    logic [PAGE_W-1:0] page_number;
    logic [CNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [PAGE_W-1:0] result_page;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLR, S_REBUILD, S_IDLE, S_CHECK, S_FIND_RD, S_FIND_CHK,
    S_SEL, S_BUD_RD, S_BUD_CHK, S_PUT_WR, S_RESP
  } ctrl_state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLR_STEP, CMD_REBUILD, CMD_BAD, CMD_NOSPACE,
    CMD_ALLOC_START, CMD_FREE_START, CMD_FIND_RD, CMD_FIND_NEXT, CMD_TAKE,
    CMD_SEL, CMD_BUD_RD, CMD_MERGE, CMD_PUT_RD, CMD_PUT_WR
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cnt_zero;
    logic op;
    logic no_space;
    logic range_bad;
    logic rem_zero;
    logic word_zero;
    logic no_buddy;
    logic buddy_set;
  } dp_status_t;

  // Smallest order whose block holds n pages.
  function automatic logic [ORD_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int k = CNT_W; k >= 0; k--) begin
      if ((32'd1 << k) >= 32'(n)) r = ORD_W'(k);
    end
    return r;
  endfunction

  // Largest order that fits in rem and keeps idx aligned, capped at the top.
  function automatic logic [ORD_W-1:0] align_order(input logic [SPAN_W-1:0] idx,
                                                   input logic [SPAN_W-1:0] rem);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int k = 1; k <= TOP_ORDER; k++) begin
      if (((32'd1 << k) <= 32'(rem)) && ((32'(idx) & ((32'd1 << k) - 32'd1)) == 32'd0))
        r = ORD_W'(k);
    end
    return r;
  endfunction

  function automatic logic [BIT_W-1:0] first_one(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (w[k]) r = BIT_W'(k);
    end
    return r;
  endfunction

endpackage

[src/buddy_page_allocator.sv]
`timescale 1ns / 1ps
// Binary buddy page allocator; top level joining controller and datapath.
// From input accept to result valid: a rejected item goes straight to the result; allocate
// scans bitmap words (up to 16) and then inserts the tail; free inserts the freed range.
// Each inserted block reads its buddy and merges while the buddy is free (up to 10 merges).
// One item at a time; the next input is taken only after the result leaves.
// Reset or a region_pages write: clearing pass over every bitmap row plus rebuild, inputs stalled.
module buddy_page_allocator import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .st        (st),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cfg_ready (cfg_ready)
  );

  bpa_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_take   (in_valid && !in_stall),
    .in_item   (in_item),
    .cfg_take  (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .out_item  (out_item)
  );

endmodule

[src/bpa_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the buddy page allocator: free-block bitmap memory, per-order
// block counts, configuration, walk registers and the result register. Uses bpa_pkg.
module bpa_datapath import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  logic             in_take,
  input  in_item_t         in_item,
  input  logic             cfg_take,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [31:0]      cfg_data,
  output dp_status_t       st,
  output out_item_t        out_item
);

  logic [WORD_W-1:0] mem [ROWS];
  logic [WORD_W-1:0] rdata;
  logic [BCNT_W-1:0] ord_cnt [NUM_ORDERS];

  logic [CNT_W-1:0]  region_pages;
  logic [PAGE_W-1:0] region_start;
  in_item_t          req;
  logic [ROW_W-1:0]  clr_ptr;
  logic [ORD_W-1:0]  ord;
  logic [WSEL_W-1:0] word;
  logic [SPAN_W-1:0] idx;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] base_idx;
  logic [SPAN_W-1:0] base_blk;
  out_item_t         result;

  logic [CNT_W-1:0]  live;
  logic [PAGE_W-1:0] rel;
  logic [ORD_W-1:0]  need;
  logic [ORD_W-1:0]  found;
  logic              any_found;
  logic [SPAN_W-1:0] buddy;
  logic [SPAN_W-1:0] blk;
  logic [SPAN_W-1:0] take_idx;
  logic [BIT_W-1:0]  take_bit;
  logic [ROW_W-1:0]  raddr;
  logic [ROW_W-1:0]  waddr;
  logic [WORD_W-1:0] wdata;
  logic              we;
  logic [WORD_W-1:0] bud_mask;
  logic [WORD_W-1:0] put_mask;
  logic [WORD_W-1:0] take_mask;

  function automatic logic [ROW_W-1:0] row_of(input logic [ORD_W-1:0] o,
                                             input logic [WSEL_W-1:0] w);
    return ROW_W'(32'(o) * WORDS + 32'(w));
  endfunction

  assign live = (region_pages > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : region_pages;
  assign rel  = req.page_number - region_start;
  assign need = ceil_log2(req.count);

  always_comb begin
    found     = '0;
    any_found = 1'b0;
    for (int k = TOP_ORDER; k >= 0; k--) begin
      if ((ORD_W'(k) >= need) && (ord_cnt[k] != '0)) begin
        found     = ORD_W'(k);
        any_found = 1'b1;
      end
    end
  end

  assign blk       = SPAN_W'(1) << ord;
  assign buddy     = idx ^ blk;
  assign take_bit  = first_one(rdata);
  assign take_idx  = SPAN_W'({word, take_bit});
  assign bud_mask  = WORD_W'(1) << buddy[BIT_W-1:0];
  assign put_mask  = WORD_W'(1) << idx[BIT_W-1:0];
  assign take_mask = WORD_W'(1) << take_bit;

  assign st.clr_last  = (clr_ptr == ROW_W'(ROWS - 1));
  assign st.cnt_zero  = (req.count == '0);
  assign st.op        = req.op;
  assign st.no_space  = (32'(need) > TOP_ORDER) || !any_found;
  assign st.range_bad = !((rel < PAGE_W'(live)) &&
                          (req.count <= (live - CNT_W'(rel))));
  assign st.rem_zero  = (rem == '0);
  assign st.word_zero = (rdata == '0);
  assign st.no_buddy  = (32'(ord) >= TOP_ORDER) || (buddy >= SPAN_W'(MAX_PAGES));
  assign st.buddy_set = |(rdata & bud_mask);

  assign out_item = result;

  // Read port and write port selection.
  always_comb begin
    raddr = row_of(ord, word);
    we    = 1'b0;
    waddr = row_of(ord, idx[IDX_W-1:BIT_W]);
    wdata = rdata | put_mask;
    unique case (cmd)
      CMD_BUD_RD: raddr = row_of(ord, buddy[IDX_W-1:BIT_W]);
      CMD_PUT_RD: raddr = row_of(ord, idx[IDX_W-1:BIT_W]);
      CMD_CLR_STEP: begin
        we    = 1'b1;
        waddr = clr_ptr;
        wdata = '0;
      end
      CMD_TAKE: begin
        we    = 1'b1;
        waddr = row_of(ord, word);
        wdata = rdata & ~take_mask;
      end
      CMD_MERGE: begin
        we    = 1'b1;
        waddr = row_of(ord, buddy[IDX_W-1:BIT_W]);
        wdata = rdata & ~bud_mask;
      end
      CMD_PUT_WR: we = (idx < SPAN_W'(MAX_PAGES));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      region_pages <= REGION_RESET;
      region_start <= '0;
      clr_ptr      <= '0;
      for (int k = 0; k < NUM_ORDERS; k++) ord_cnt[k] <= '0;
    end else begin
      if (cfg_take) begin
        if (cfg_index == REG_REGION_PAGES) begin
          region_pages <= cfg_data[CNT_W-1:0];
          clr_ptr      <= '0;
          for (int k = 0; k < NUM_ORDERS; k++) ord_cnt[k] <= '0;
        end else begin
          region_start <= cfg_data[PAGE_W-1:0];
        end
      end
      unique case (cmd)
        CMD_CLR_STEP: clr_ptr <= clr_ptr + ROW_W'(1);
        CMD_TAKE, CMD_MERGE: ord_cnt[ord] <= ord_cnt[ord] - BCNT_W'(1);
        CMD_PUT_WR: begin
          if ((idx < SPAN_W'(MAX_PAGES)) && !(|(rdata & put_mask)))
            ord_cnt[ord] <= ord_cnt[ord] + BCNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) req <= in_item;
    unique case (cmd)
      CMD_REBUILD: begin
        idx <= '0;
        rem <= SPAN_W'(live);
      end
      CMD_BAD: result <= '{status: ST_BAD, result_page: '0};
      CMD_NOSPACE: result <= '{status: ST_NO_SPACE, result_page: '0};
      CMD_ALLOC_START: begin
        result <= '{status: ST_OK, result_page: '0};
        ord    <= found;
        word   <= '0;
      end
      CMD_FREE_START: begin
        result <= '{status: ST_OK, result_page: '0};
        idx    <= SPAN_W'(rel);
        rem    <= SPAN_W'(req.count);
      end
      CMD_FIND_NEXT: word <= word + WSEL_W'(1);
      CMD_TAKE: begin
        result.result_page <= region_start + PAGE_W'(take_idx);
        idx <= take_idx + SPAN_W'(req.count);
        // Hand back the unused tail of the block.
        rem <= (blk > SPAN_W'(req.count)) ? blk - SPAN_W'(req.count) : '0;
      end
      CMD_SEL: begin
        ord      <= align_order(idx, rem);
        base_idx <= idx;
        base_blk <= SPAN_W'(1) << align_order(idx, rem);
      end
      CMD_MERGE: begin
        idx <= idx & ~((blk << 1) - SPAN_W'(1));
        ord <= ord + ORD_W'(1);
      end
      CMD_PUT_WR: begin
        // Advance past the block as split from the range, not as merged.
        idx <= base_idx + base_blk;
        rem <= rem - base_blk;
      end
      default: ;
    endcase
  end

endmodule

[src/bpa_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the buddy page allocator: sequences clearing, rebuild,
// search, split and merge steps. Uses bpa_pkg.
module bpa_ctrl import bpa_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  input  logic [REG_W-1:0] cfg_index,
  input  dp_status_t       st,
  output dp_cmd_t          cmd,
  output logic             in_stall,
  output logic             out_valid,
  output logic             cfg_ready
);

  ctrl_state_t state, state_next;
  logic        quiet, quiet_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      quiet <= 1'b1;
    end else begin
      state <= state_next;
      quiet <= quiet_next;
    end
  end

  always_comb begin
    state_next = state;
    quiet_next = quiet;
    unique case (state)
      S_CLR:     if (st.clr_last) state_next = S_REBUILD;
      S_REBUILD: state_next = S_SEL;
      S_IDLE: begin
        // A register write goes first; the input item waits.
        if (cfg_valid) begin
          if (cfg_index == REG_REGION_PAGES) begin
            state_next = S_CLR;
            quiet_next = 1'b1;
          end
        end else if (in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.cnt_zero) state_next = S_RESP;
        else if (st.op == OP_ALLOC) state_next = st.no_space ? S_RESP : S_FIND_RD;
        else state_next = st.range_bad ? S_RESP : S_SEL;
      end
      S_FIND_RD:  state_next = S_FIND_CHK;
      S_FIND_CHK: state_next = st.word_zero ? S_FIND_RD : S_SEL;
      S_SEL: begin
        if (st.rem_zero) begin
          state_next = quiet ? S_IDLE : S_RESP;
          quiet_next = 1'b0;
        end else begin
          state_next = S_BUD_RD;
        end
      end
      S_BUD_RD:  state_next = st.no_buddy ? S_PUT_WR : S_BUD_CHK;
      S_BUD_CHK: state_next = st.buddy_set ? S_BUD_RD : S_PUT_WR;
      S_PUT_WR:  state_next = S_SEL;
      S_RESP:    if (!out_stall) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = CMD_NONE;
    in_stall  = (state != S_IDLE) || cfg_valid;
    cfg_ready = (state == S_IDLE);
    out_valid = (state == S_RESP);
    unique case (state)
      S_CLR:     cmd = CMD_CLR_STEP;
      S_REBUILD: cmd = CMD_REBUILD;
      S_CHECK: begin
        if (st.cnt_zero) cmd = CMD_BAD;
        else if (st.op == OP_ALLOC) cmd = st.no_space ? CMD_NOSPACE : CMD_ALLOC_START;
        else cmd = st.range_bad ? CMD_BAD : CMD_FREE_START;
      end
      S_FIND_RD:  cmd = CMD_FIND_RD;
      S_FIND_CHK: cmd = st.word_zero ? CMD_FIND_NEXT : CMD_TAKE;
      S_SEL:      if (!st.rem_zero) cmd = CMD_SEL;
      S_BUD_RD:   cmd = st.no_buddy ? CMD_PUT_RD : CMD_BUD_RD;
      S_BUD_CHK:  cmd = st.buddy_set ? CMD_MERGE : CMD_PUT_RD;
      S_PUT_WR:   cmd = CMD_PUT_WR;
      default:    cmd = CMD_NONE;
    endcase
  end

endmodule
